@@ rtl/ps2_mouse_packet_cursor_tracker_assert.svh @@
// assertion macros for the ps2 mouse cursor tracker
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PS2MCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2mct: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PS2MCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2mct: next-cycle check failed");

`endif

@@ rtl/ps2mct_pkg.sv @@
// shared types, constants and helper functions for the ps2 mouse cursor tracker
package ps2mct_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int BOUND_WIDTH = 13;
   localparam int BYTE_WIDTH = 8;
   localparam int BUTTON_WIDTH = 3;
   localparam int SYNC_BIT = 3;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [BOUND_WIDTH-1:0] bound_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [BUTTON_WIDTH-1:0] button_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam coord_type CoordMax = {COORD_WIDTH{1'b1}};
   localparam bound_type ResetWidth = BOUND_WIDTH'(800);
   localparam bound_type ResetHeight = BOUND_WIDTH'(600);

   localparam csr_index_type CSR_SCREEN_WIDTH = CSR_INDEX_WIDTH'(0);
   localparam csr_index_type CSR_SCREEN_HEIGHT = CSR_INDEX_WIDTH'(1);

   typedef enum logic [1:0] {
      POS_HEADER = 2'd0,
      POS_XDELTA = 2'd1,
      POS_YDELTA = 2'd2
   } byte_pos_type;

   // one decoded packet, valid when done is set
   typedef struct packed {
      logic done;
      button_type buttons;
      logic signed [BYTE_WIDTH-1:0] dx;
      logic signed [BYTE_WIDTH-1:0] dy;
   } pkt_type;

   // largest coordinate a bound allows; zero bound acts as one
   function automatic coord_type limit_of(input bound_type bound);
      bound_type lim;
      lim = (bound == '0) ? '0 : bound - BOUND_WIDTH'(1);
      if (lim > BOUND_WIDTH'(CoordMax)) begin
         return CoordMax;
      end
      return COORD_WIDTH'(lim);
   endfunction

   function automatic coord_type half_of(input bound_type bound);
      bound_type h;
      h = bound >> 1;
      if (h > BOUND_WIDTH'(CoordMax)) begin
         return CoordMax;
      end
      return COORD_WIDTH'(h);
   endfunction

endpackage

@@ rtl/ps2mct_framer.sv @@
// three-byte packet framing with header sync recovery
module ps2mct_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ps2mct_pkg::byte_type  data_byte,
   input  logic                  from_aux,
   output ps2mct_pkg::pkt_type   pkt
);
   import ps2mct_pkg::*;

   byte_pos_type pos_ff, pos_in;
   byte_type header_ff, header_in;
   byte_type xdelta_ff, xdelta_in;

   // next state
   always_comb begin
      pos_in = pos_ff;
      header_in = header_ff;
      xdelta_in = xdelta_ff;
      if (step && from_aux) begin
         unique case (pos_ff)
            POS_HEADER: begin
               // a header without its sync bit is dropped
               if (data_byte[SYNC_BIT]) begin
                  header_in = data_byte;
                  pos_in = POS_XDELTA;
               end
            end
            POS_XDELTA: begin
               xdelta_in = data_byte;
               pos_in = POS_YDELTA;
            end
            POS_YDELTA: begin
               pos_in = POS_HEADER;
            end
            default: begin
               pos_in = POS_HEADER;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      pkt.done = from_aux && (pos_ff == POS_YDELTA);
      pkt.buttons = header_ff[BUTTON_WIDTH-1:0];
      pkt.dx = xdelta_ff;
      pkt.dy = data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HEADER;
         header_ff <= '0;
         xdelta_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         header_ff <= header_in;
         xdelta_ff <= xdelta_in;
      end
   end

endmodule

@@ rtl/ps2mct_cursor.sv @@
// bound registers and clamped cursor position
module ps2mct_cursor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  ps2mct_pkg::pkt_type        pkt,
   input  logic                       csr_write,
   input  ps2mct_pkg::csr_index_type  csr_index,
   input  ps2mct_pkg::bound_type      csr_wdata,
   output ps2mct_pkg::coord_type      next_x,
   output ps2mct_pkg::coord_type      next_y
);
   import ps2mct_pkg::*;

   localparam int SumWidth = COORD_WIDTH + 2;

   bound_type width_ff, width_in;
   bound_type height_ff, height_in;
   coord_type lim_x_ff, lim_x_in;
   coord_type lim_y_ff, lim_y_in;
   coord_type pos_x_ff, pos_x_in;
   coord_type pos_y_ff, pos_y_in;
   logic signed [SumWidth-1:0] sum_x;
   logic signed [SumWidth-1:0] sum_y;

   function automatic coord_type clamp(input logic signed [SumWidth-1:0] v,
                                       input coord_type lim);
      if (v < 0) begin
         return '0;
      end
      if (v[SumWidth-2:0] > {1'b0, lim}) begin
         return lim;
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      sum_x = $signed({2'b00, pos_x_ff}) + SumWidth'(pkt.dx);
      // screen y grows downward
      sum_y = $signed({2'b00, pos_y_ff}) - SumWidth'(pkt.dy);
      next_x = clamp(sum_x, lim_x_ff);
      next_y = clamp(sum_y, lim_y_ff);
   end

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (csr_write && (csr_index == CSR_SCREEN_WIDTH)) begin
         width_in = csr_wdata;
      end
      if (csr_write && (csr_index == CSR_SCREEN_HEIGHT)) begin
         height_in = csr_wdata;
      end
      lim_x_in = limit_of(width_in);
      lim_y_in = limit_of(height_in);
      priority if (csr_write) begin
         pos_x_in = half_of(width_in);
         pos_y_in = half_of(height_in);
      end else if (step) begin
         pos_x_in = next_x;
         pos_y_in = next_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ResetWidth;
         height_ff <= ResetHeight;
         lim_x_ff <= limit_of(ResetWidth);
         lim_y_ff <= limit_of(ResetHeight);
         pos_x_ff <= half_of(ResetWidth);
         pos_y_ff <= half_of(ResetHeight);
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         lim_x_ff <= lim_x_in;
         lim_y_ff <= lim_y_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

endmodule

@@ rtl/ps2_mouse_packet_cursor_tracker.sv @@
// ps2 mouse cursor tracker: request register, framer, cursor update, response register
//
// Takes one byte per clock while req_stall is low. A request lands in an
// input register, is decoded against the packet framing state in the next
// cycle, and when it completes a three-byte mouse packet the clamped cursor
// and buttons load into the response register, which the third byte reaches
// after the input register. Bytes that finish no packet never stall; a
// packet's last byte waits only while a previous response is still stalled.
// Writing either bound register recenters the cursor to half of each bound.
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module ps2_mouse_packet_cursor_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ps2mct_pkg::byte_type       req_data_byte,
   input  logic                       req_from_aux,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ps2mct_pkg::coord_type      rsp_cursor_x,
   output ps2mct_pkg::coord_type      rsp_cursor_y,
   output ps2mct_pkg::button_type     rsp_button_bits,
   input  logic                       csr_write,
   input  ps2mct_pkg::csr_index_type  csr_index,
   input  ps2mct_pkg::bound_type      csr_wdata
);
   import ps2mct_pkg::*;

   logic in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic in_aux_ff;
   logic out_valid_ff, out_valid_in;
   coord_type out_x_ff;
   coord_type out_y_ff;
   button_type out_btn_ff;
   pkt_type pkt;
   logic advance;
   logic emit;
   coord_type next_x;
   coord_type next_y;

   ps2mct_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .from_aux  (in_aux_ff),
      .pkt       (pkt)
   );

   ps2mct_cursor u_cursor (
      .clock     (clock),
      .reset     (reset),
      .step      (emit),
      .pkt       (pkt),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .next_x    (next_x),
      .next_y    (next_y)
   );

   // a held request moves on unless it needs the response slot and that is full and stalled
   assign advance = in_valid_ff && (!pkt.done || !out_valid_ff || !rsp_stall);
   assign emit = advance && pkt.done;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      priority if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_aux_ff <= req_from_aux;
      end
      if (emit) begin
         out_x_ff <= next_x;
         out_y_ff <= next_y;
         out_btn_ff <= pkt.buttons;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_cursor_x = out_x_ff;
   assign rsp_cursor_y = out_y_ff;
   assign rsp_button_bits = out_btn_ff;

   `PS2MCT_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid)
   `PS2MCT_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff)
   `PS2MCT_ASSERT_NOW(a_no_stall_mid_packet, clock, reset, in_valid_ff && !pkt.done, !req_stall)
   `PS2MCT_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall, out_valid_ff && rsp_stall)

endmodule
